// ===== hdl/mi3_pkg.sv =====
`default_nettype none
package mi3_pkg;

    localparam int EW    = 32;
    localparam int PW    = 2 * EW;
    localparam int CW    = PW + 1;
    localparam int DW    = 99;
    localparam int NW    = 98;
    localparam int STEPS = 31;
    localparam int RW    = NW + STEPS;
    localparam int LANES = 9;

    typedef logic signed [EW-1:0] elem_t;
    typedef logic signed [PW-1:0] prod_t;
    typedef logic signed [CW-1:0] cross_t;
    typedef logic signed [DW-1:0] det_t;
    typedef logic [NW-1:0]        mag_t;
    typedef logic [RW-1:0]        rem_t;
    typedef logic [STEPS-1:0]     quot_t;

    localparam elem_t SAT_POS = 32'sh7FFF_FFFF;
    localparam elem_t SAT_NEG = 32'sh8000_0000;

endpackage
`default_nettype wire

// ===== hdl/matrix3x3_inverse.sv =====
// 3x3 matrix inverse, signed Q16.16 in and out, adjugate over determinant.
// Input channel s_valid/s_ready carries the nine elements s_aRC of one matrix
// per transaction. Output channel m_valid/m_ready carries the nine inverse
// elements m_bRC and m_singular, which is set with all elements zero when
// the determinant is exactly zero. Quotients are rounded to nearest, ties
// away from zero, and saturated to 32 bits.
// From input transaction to m_valid the stages are: one multiply
// stage for the cofactor products, one subtract, one split multiply and one
// sum for the determinant, one magnitude stage, one overflow check, then 31
// restoring division steps (one quotient bit per stage) and the output
// register. Throughput is one matrix per cycle while the output is not stalled.
// The whole pipeline advances whenever the output register is empty or
// being taken; while the receiver stalls a full output, s_ready is low and
// every stage holds, bubbles included. They drain once the output is taken.
// aresetn is synchronous, active low, and clears all valid bits; the data
// path is not reset.
`default_nettype none
module matrix3x3_inverse (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  mi3_pkg::elem_t  s_a00,
    input  mi3_pkg::elem_t  s_a01,
    input  mi3_pkg::elem_t  s_a02,
    input  mi3_pkg::elem_t  s_a10,
    input  mi3_pkg::elem_t  s_a11,
    input  mi3_pkg::elem_t  s_a12,
    input  mi3_pkg::elem_t  s_a20,
    input  mi3_pkg::elem_t  s_a21,
    input  mi3_pkg::elem_t  s_a22,
    output logic            m_valid,
    input  logic            m_ready,
    output mi3_pkg::elem_t  m_b00,
    output mi3_pkg::elem_t  m_b01,
    output mi3_pkg::elem_t  m_b02,
    output mi3_pkg::elem_t  m_b10,
    output mi3_pkg::elem_t  m_b11,
    output mi3_pkg::elem_t  m_b12,
    output mi3_pkg::elem_t  m_b20,
    output mi3_pkg::elem_t  m_b21,
    output mi3_pkg::elem_t  m_b22,
    output logic            m_singular
);
    import mi3_pkg::*;

    logic   en;
    elem_t  a [0:LANES-1];

    logic   v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    prod_t  pa_reg [0:LANES-1];
    prod_t  pb_reg [0:LANES-1];
    elem_t  a1_reg [0:2];
    elem_t  a2_reg [0:2];
    cross_t c2_reg [0:LANES-1];
    cross_t c3_reg [0:LANES-1];
    cross_t c4_reg [0:LANES-1];
    cross_t plo_reg [0:2];
    cross_t phi_reg [0:2];
    det_t   det_reg;
    det_t   det_next;
    det_t   dmag;

    mag_t   num_reg [0:LANES-1];
    logic   neg5_reg [0:LANES-1];
    mag_t   den5_reg;
    logic   sing5_reg;

    rem_t   rem_reg  [0:STEPS][0:LANES-1];
    quot_t  q_reg    [0:STEPS][0:LANES-1];
    logic   neg_reg  [0:STEPS][0:LANES-1];
    logic   sat_reg  [0:STEPS][0:LANES-1];
    mag_t   den_reg  [0:STEPS];
    logic   sing_reg [0:STEPS];
    logic   vd_reg   [0:STEPS];

    logic   m_valid_reg;
    logic   m_singular_reg;
    elem_t  m_b_reg  [0:LANES-1];
    elem_t  m_b_next [0:LANES-1];

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    assign a[0] = s_a00; assign a[1] = s_a01; assign a[2] = s_a02;
    assign a[3] = s_a10; assign a[4] = s_a11; assign a[5] = s_a12;
    assign a[6] = s_a20; assign a[7] = s_a21; assign a[8] = s_a22;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            v5_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            v1_reg      <= s_valid;
            v2_reg      <= v1_reg;
            v3_reg      <= v2_reg;
            v4_reg      <= v3_reg;
            v5_reg      <= v4_reg;
            m_valid_reg <= vd_reg[STEPS];
        end
    end

    // cofactor products and differences; lane i*3+j is row i col j of the adjugate
    for (genvar l = 0; l < LANES; l++) begin : g_cof
        localparam int I  = l / 3;
        localparam int J  = l % 3;
        localparam int R1 = (J + 1) % 3;
        localparam int R2 = (J + 2) % 3;
        localparam int K1 = (I + 1) % 3;
        localparam int K2 = (I + 2) % 3;
        prod_t pa_next, pb_next;
        assign pa_next = prod_t'(a[R1*3+K1]) * prod_t'(a[R2*3+K2]);
        assign pb_next = prod_t'(a[R2*3+K1]) * prod_t'(a[R1*3+K2]);
        always_ff @(posedge aclk) begin
            if (en) begin
                pa_reg[l] <= pa_next;
                pb_reg[l] <= pb_next;
                c2_reg[l] <= cross_t'(pa_reg[l]) - cross_t'(pb_reg[l]);
                c3_reg[l] <= c2_reg[l];
                c4_reg[l] <= c3_reg[l];
            end
        end
    end

    // determinant: column 0 dotted with row 0 of the adjugate, split multiply
    for (genvar j = 0; j < 3; j++) begin : g_det
        always_ff @(posedge aclk) begin
            if (en) begin
                a1_reg[j]  <= a[j*3];
                a2_reg[j]  <= a1_reg[j];
                plo_reg[j] <= cross_t'(a2_reg[j])
                              * cross_t'($signed({1'b0, c2_reg[j][EW-1:0]}));
                phi_reg[j] <= cross_t'(a2_reg[j])
                              * cross_t'($signed(c2_reg[j][CW-1:EW]));
            end
        end
    end

    always_comb begin
        det_next = '0;
        for (int j = 0; j < 3; j++) begin
            det_next = det_next + (det_t'(phi_reg[j]) <<< EW) + det_t'(plo_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= det_next;
        end
    end

    assign dmag = det_reg[DW-1] ? -det_reg : det_reg;

    // magnitudes: num = 2|c|*2^32 + |d|, den = 2|d|
    always_ff @(posedge aclk) begin
        if (en) begin
            den5_reg  <= {dmag[NW-2:0], 1'b0};
            sing5_reg <= (det_reg == '0);
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_mag
        cross_t cmag;
        assign cmag = c4_reg[l][CW-1] ? -c4_reg[l] : c4_reg[l];
        always_ff @(posedge aclk) begin
            if (en) begin
                num_reg[l]  <= mag_t'({cmag[CW-2:0], 33'b0}) + mag_t'(dmag);
                neg5_reg[l] <= c4_reg[l][CW-1] ^ det_reg[DW-1];
            end
        end
    end

    // division stage 0: saturation check, then one quotient bit per stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vd_reg[0] <= 1'b0;
        end else if (en) begin
            vd_reg[0] <= v5_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            den_reg[0]  <= den5_reg;
            sing_reg[0] <= sing5_reg;
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_div0
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[0][l] <= rem_t'(num_reg[l]);
                q_reg[0][l]   <= '0;
                neg_reg[0][l] <= neg5_reg[l];
                sat_reg[0][l] <= rem_t'(num_reg[l]) >= {den5_reg, {STEPS{1'b0}}};
            end
        end
    end

    for (genvar s = 1; s <= STEPS; s++) begin : g_step
        localparam int K = STEPS - s;
        rem_t dsh;
        assign dsh = rem_t'(den_reg[s-1]) << K;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vd_reg[s] <= 1'b0;
            end else if (en) begin
                vd_reg[s] <= vd_reg[s-1];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                den_reg[s]  <= den_reg[s-1];
                sing_reg[s] <= sing_reg[s-1];
            end
        end
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            logic fit;
            assign fit = rem_reg[s-1][l] >= dsh;
            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[s][l] <= fit ? rem_reg[s-1][l] - dsh : rem_reg[s-1][l];
                    q_reg[s][l]   <= q_reg[s-1][l] | (quot_t'(fit) << K);
                    neg_reg[s][l] <= neg_reg[s-1][l];
                    sat_reg[s][l] <= sat_reg[s-1][l];
                end
            end
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_out
        always_comb begin
            if (sing_reg[STEPS]) begin
                m_b_next[l] = '0;
            end else if (sat_reg[STEPS][l]) begin
                m_b_next[l] = neg_reg[STEPS][l] ? SAT_NEG : SAT_POS;
            end else if (neg_reg[STEPS][l]) begin
                m_b_next[l] = -elem_t'({1'b0, q_reg[STEPS][l]});
            end else begin
                m_b_next[l] = elem_t'({1'b0, q_reg[STEPS][l]});
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                m_b_reg[l] <= m_b_next[l];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_singular_reg <= sing_reg[STEPS];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_singular = m_singular_reg;
    assign m_b00 = m_b_reg[0]; assign m_b01 = m_b_reg[1]; assign m_b02 = m_b_reg[2];
    assign m_b10 = m_b_reg[3]; assign m_b11 = m_b_reg[4]; assign m_b12 = m_b_reg[5];
    assign m_b20 = m_b_reg[6]; assign m_b21 = m_b_reg[7]; assign m_b22 = m_b_reg[8];

    a_sing_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> ({m_b00, m_b01, m_b02, m_b10, m_b11, m_b12,
                                    m_b20, m_b21, m_b22} == '0))
        else $error("singular result with nonzero elements");

    a_den_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        vd_reg[0] && !sing_reg[0] |-> den_reg[0] != '0)
        else $error("zero divisor on nonsingular transaction");

    a_rem_lt: assert property (@(posedge aclk) disable iff (!aresetn)
        vd_reg[STEPS] && !sing_reg[STEPS] && !sat_reg[STEPS][0]
            |-> rem_reg[STEPS][0] < rem_t'(den_reg[STEPS]))
        else $error("division remainder not below divisor");

    a_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> v1_reg)
        else $error("accepted transaction lost at first stage");

endmodule
`default_nettype wire
